// ===== hdl/rk4_pkg.sv =====
// ---------------------------------------------------------------------------
// rk4_pkg
// Shared constants, command codes and status types for the RK4 integrator.
// ---------------------------------------------------------------------------
package rk4_pkg;

	localparam int MaxStepsDefault = 64;
	localparam int FracBitsDefault = 24;
	localparam int WordW = 32;
	localparam int CountW = 7;
	localparam int IndexW = 6;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIVH,
		OP_SLOPE,
		OP_FINISH
	} rk4_op_t;

	typedef struct packed {
		rk4_op_t    op;
		logic [1:0] stage;
	} rk4_cmd_t;

	typedef struct packed {
		logic done;
		logic zero_count;
	} rk4_status_t;

	function automatic logic signed [WordW-1:0] sat32(input logic signed [WordW+1:0] v);
		logic signed [WordW+1:0] hi;
		logic signed [WordW+1:0] lo;
		hi = (WordW+2)'(signed'({1'b0, {(WordW-1){1'b1}}}));
		lo = -hi - (WordW+2)'(1);
		if (v > hi) return {1'b0, {(WordW-1){1'b1}}};
		if (v < lo) return {1'b1, {(WordW-1){1'b0}}};
		return v[WordW-1:0];
	endfunction

endpackage

// ===== hdl/rk4_ode_integrator.sv =====
// ---------------------------------------------------------------------------
// rk4_ode_integrator
// Fourth-order Runge-Kutta integration of dy/dx=(y^2-x^2)/(y^2+x^2), Q8.24.
// ---------------------------------------------------------------------------
// channel   handshake           fields
// request   start / busy        x_start y_start x_end step_count
// result    done (strobe)       x_value y_before y_after step_index last divide_fault
//
// A request runs in order: a restoring divider forms the step size, then each
// step takes four slope evaluations (a restoring divide each) and a finish
// that strobes the result.
// busy stays high while the last result is strobed and drops in the cycle after.
// Reset clears the controller and datapath sequencing; results are shown for
// one cycle only and the receiver cannot stall them.
module rk4_ode_integrator import rk4_pkg::*; #(
	parameter int MAX_STEPS = MaxStepsDefault,
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [WordW-1:0] x_start,
	input  logic signed [WordW-1:0] y_start,
	input  logic signed [WordW-1:0] x_end,
	input  logic [CountW-1:0]       step_count,
	output logic                    done,
	output logic signed [WordW-1:0] x_value,
	output logic signed [WordW-1:0] y_before,
	output logic signed [WordW-1:0] y_after,
	output logic [IndexW-1:0]       step_index,
	output logic                    last,
	output logic                    divide_fault
);

	rk4_cmd_t    cmd;
	rk4_status_t status;
	logic        capture;

	rk4_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.capture(capture), .status(status), .cmd(cmd)
	);

	rk4_dp #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .capture(capture), .cmd(cmd), .status(status),
		.x_start(x_start), .y_start(y_start), .x_end(x_end),
		.step_count(step_count), .done(done), .x_value(x_value),
		.y_before(y_before), .y_after(y_after), .step_index(step_index),
		.last(last), .divide_fault(divide_fault)
	);

endmodule

// ===== hdl/rk4_ctrl.sv =====
// ---------------------------------------------------------------------------
// rk4_ctrl
// Sequencer: load, step-size divide, then per step four slope evaluations and a finish.
// ---------------------------------------------------------------------------
module rk4_ctrl import rk4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        capture,
	input  rk4_status_t status,
	output rk4_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIVH,
		ST_SLOPE,
		ST_FINISH
	} state_t;

	state_t     state_q;
	logic [1:0] stage_q;

	// hold state; issue one command per operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= '0;
			cmd     <= '{op: OP_NONE, stage: 2'd0};
		end else begin
			cmd <= '{op: OP_NONE, stage: stage_q};
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOAD;
						cmd     <= '{op: OP_LOAD, stage: 2'd0};
					end
				end
				ST_LOAD: begin
					if (status.zero_count) begin
						state_q <= ST_IDLE;
					end else if (status.done) begin
						state_q <= ST_DIVH;
						cmd     <= '{op: OP_DIVH, stage: 2'd0};
					end
				end
				ST_DIVH: begin
					if (status.done) begin
						state_q <= ST_SLOPE;
						stage_q <= '0;
						cmd     <= '{op: OP_SLOPE, stage: 2'd0};
					end
				end
				ST_SLOPE: begin
					if (status.done) begin
						if (stage_q == 2'd3) begin
							state_q <= ST_FINISH;
							cmd     <= '{op: OP_FINISH, stage: 2'd3};
						end else begin
							stage_q <= stage_q + 2'd1;
							cmd     <= '{op: OP_SLOPE, stage: stage_q + 2'd1};
						end
					end
				end
				ST_FINISH: begin
					if (status.done) begin
						state_q <= ST_SLOPE;
						stage_q <= '0;
						cmd     <= '{op: OP_SLOPE, stage: 2'd0};
					end else if (status.zero_count) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// take the request operands on the accepting edge
	assign capture = (state_q == ST_IDLE) && start;

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_LOAD))
		else $error("start not taken");
	a_stage_in_slope: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (stage_q == 2'd3))
		else $error("finish without four slopes");
	a_load_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && $past(state_q) != ST_LOAD) |-> $past(start))
		else $error("load without request");

endmodule

// ===== hdl/rk4_dp.sv =====
// ---------------------------------------------------------------------------
// rk4_dp
// Datapath: operand registers, a shared multiplier, restoring dividers for the
// slope and the step size (one quotient bit per cycle) and the weighted sum.
// ---------------------------------------------------------------------------
module rk4_dp import rk4_pkg::*; #(
	parameter int MAX_STEPS = MaxStepsDefault,
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     capture,
	input  rk4_cmd_t                 cmd,
	output rk4_status_t              status,
	input  logic signed [WordW-1:0]  x_start,
	input  logic signed [WordW-1:0]  y_start,
	input  logic signed [WordW-1:0]  x_end,
	input  logic [CountW-1:0]        step_count,
	output logic                     done,
	output logic signed [WordW-1:0]  x_value,
	output logic signed [WordW-1:0]  y_before,
	output logic signed [WordW-1:0]  y_after,
	output logic [IndexW-1:0]        step_index,
	output logic                     last,
	output logic                     divide_fault
);

	localparam int MaxCnt = MAX_STEPS;
	localparam int DivW = 2*WordW + 2;   // numerator/denominator width
	localparam int DCntW = 7;
	localparam int SumW = WordW + 3;     // k1 + 2*k2 + 2*k3 + k4
	// ceil(2^34 / 3): exact floor(n / 3) for n below 2^33
	localparam logic [WordW:0] Recip3 = 33'h1_5555_5556;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SQ_X, PH_SQ_Y, PH_MUL, PH_DIV, PH_SUM, PH_DIV6, PH_OUT, PH_HDIV
	} phase_t;

	logic signed [WordW-1:0] x_q, y_q, xe_q, x0_q, y0_q, h_q, hh_q;
	logic signed [WordW-1:0] k_q [4];
	logic [CountW-1:0]       cnt_q;
	logic [IndexW:0]         idx_q;
	logic                    fault_q;
	phase_t                  ph_q;
	logic [1:0]              stg_q;
	logic signed [WordW-1:0] ex_q, ey_q;     // evaluation point
	logic [2*WordW-1:0]      x2_q, y2_q;
	logic [DivW-1:0]         rem_q, den_q;
	logic [WordW:0]          quo_q;
	logic [DCntW-1:0]        dcnt_q;
	logic                    neg_q;
	logic [WordW-1:0]        hquo_q;
	logic [CountW-1:0]       hrem_q;
	logic                    hneg_q;
	logic                    sum_neg_q;
	logic [WordW:0]          sum_half_q;
	logic [WordW-1:0]        q6_q;
	logic                    done_q, zc_q;

	// shared multiplier: 32x32 magnitudes
	logic [WordW-1:0]        ma, mb;
	logic [2*WordW-1:0]      mprod;
	logic signed [WordW+1:0] slope_s;
	logic signed [2*WordW+1:0] kprod;
	logic signed [SumW-1:0]  wsum;
	logic [SumW-1:0]         wmag;
	logic [2*WordW+1:0]      prod6;
	logic signed [WordW+1:0] q6s;
	logic signed [WordW+1:0] ypre;
	logic signed [WordW-1:0] xm, xf;
	logic [DivW-1:0]         rsh;
	logic [DivW-1:0]         mag;
	logic signed [WordW+1:0] hdiff;
	logic [WordW-1:0]        hmag;
	logic [CountW:0]         htrial;
	logic signed [WordW+1:0] hval;
	logic signed [WordW-1:0] hsat;

	assign xm = sat32((WordW+2)'(x_q) + (WordW+2)'(hh_q));
	assign xf = sat32((WordW+2)'(x_q) + (WordW+2)'(h_q));
	assign ma = (ph_q == PH_SQ_X) ? (ex_q[WordW-1] ? WordW'(-ex_q) : WordW'(ex_q))
	                              : (ey_q[WordW-1] ? WordW'(-ey_q) : WordW'(ey_q));
	assign mb = ma;
	assign mprod = (2*WordW)'(ma) * (2*WordW)'(mb);
	assign slope_s = neg_q ? -signed'((WordW+2)'(quo_q)) : signed'((WordW+2)'(quo_q));
	assign kprod = (2*WordW+2)'(h_q) * (2*WordW+2)'(slope_s);
	assign rsh = {rem_q[DivW-2:0], 1'b0};
	assign mag = (y2_q >= x2_q) ? DivW'(y2_q - x2_q) : DivW'(x2_q - y2_q);

	// weighted sum, then |sum| / 6 as (|sum| / 2) / 3 by reciprocal
	assign wsum = SumW'(k_q[0]) + (SumW'(k_q[1]) <<< 1)
	            + (SumW'(k_q[2]) <<< 1) + SumW'(k_q[3]);
	assign wmag = wsum[SumW-1] ? SumW'(-wsum) : SumW'(wsum);
	assign prod6 = (2*WordW+2)'(sum_half_q) * (2*WordW+2)'(Recip3);
	assign q6s = signed'((WordW+2)'(q6_q));
	assign ypre = (WordW+2)'(y_q) + (sum_neg_q ? -q6s : q6s);

	// step size: |x_end - x_start| / count, one quotient bit per cycle
	assign hdiff = (WordW+2)'(xe_q) - (WordW+2)'(x_q);
	assign hmag = hdiff[WordW+1] ? WordW'(-hdiff) : WordW'(hdiff);
	assign htrial = {hrem_q, hquo_q[WordW-1]};
	assign hval = hneg_q ? -signed'((WordW+2)'(hquo_q)) : signed'((WordW+2)'(hquo_q));
	assign hsat = sat32(hval);

	// run one operation at a time; status done or zero_count pulses when it completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
			zc_q   <= 1'b0;
			done   <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			zc_q   <= 1'b0;
			done   <= 1'b0;
			// hold the request operands from the accepting edge
			if (capture) begin
				x_q   <= x_start;
				y_q   <= y_start;
				xe_q  <= x_end;
				cnt_q <= (step_count > CountW'(MaxCnt)) ? CountW'(MaxCnt) : step_count;
			end
			unique case (cmd.op)
				OP_LOAD: begin
					idx_q  <= '0;
					zc_q   <= (cnt_q == '0);
					done_q <= (cnt_q != '0);
				end
				OP_DIVH: begin
					hneg_q <= hdiff[WordW+1];
					hquo_q <= hmag;
					hrem_q <= '0;
					dcnt_q <= '0;
					ph_q   <= PH_HDIV;
				end
				OP_SLOPE: begin
					stg_q <= cmd.stage;
					if (cmd.stage == 2'd0) begin
						fault_q <= 1'b0;
						x0_q <= x_q;
						y0_q <= y_q;
						ex_q <= x_q;
						ey_q <= y_q;
					end else if (cmd.stage == 2'd3) begin
						ex_q <= xf;
						ey_q <= sat32((WordW+2)'(y_q) + (WordW+2)'(k_q[2]));
					end else begin
						ex_q <= xm;
						ey_q <= sat32((WordW+2)'(y_q) + ((WordW+2)'(k_q[cmd.stage-2'd1]) >>> 1));
					end
					ph_q <= PH_SQ_X;
				end
				OP_FINISH: begin
					ph_q <= PH_SUM;
				end
				default: ;
			endcase
			unique case (ph_q)
				PH_SQ_X: begin
					x2_q <= mprod;
					ph_q <= PH_SQ_Y;
				end
				PH_SQ_Y: begin
					y2_q <= mprod;
					ph_q <= PH_MUL;
					dcnt_q <= '0;
				end
				PH_MUL: begin
					// set up the ratio
					den_q  <= DivW'(x2_q) + DivW'(y2_q);
					rem_q  <= mag;
					neg_q  <= (y2_q < x2_q);
					quo_q  <= '0;
					ph_q   <= PH_DIV;
				end
				PH_DIV: begin
					if (den_q == '0) begin
						fault_q <= 1'b1;
						k_q[stg_q] <= '0;
						ph_q <= PH_IDLE;
						done_q <= 1'b1;
					end else if (rem_q == den_q && dcnt_q == '0) begin
						quo_q  <= (WordW+1)'(1) << FRAC_BITS;
						dcnt_q <= DCntW'(FRAC_BITS);
					end else if (dcnt_q < DCntW'(FRAC_BITS)) begin
						dcnt_q <= dcnt_q + DCntW'(1);
						if (rsh >= den_q) begin
							rem_q <= rsh - den_q;
							quo_q <= {quo_q[WordW-1:0], 1'b1};
						end else begin
							rem_q <= rsh;
							quo_q <= {quo_q[WordW-1:0], 1'b0};
						end
					end else begin
						k_q[stg_q] <= sat32((WordW+2)'(kprod >>> FRAC_BITS));
						ph_q   <= PH_IDLE;
						done_q <= 1'b1;
					end
				end
				PH_SUM: begin
					sum_neg_q  <= wsum[SumW-1];
					sum_half_q <= wmag[SumW-2:1];
					ph_q       <= PH_DIV6;
				end
				PH_DIV6: begin
					q6_q <= prod6[2*WordW+1:WordW+2];
					ph_q <= PH_OUT;
				end
				PH_OUT: begin
					x_value    <= x0_q;
					y_before   <= y0_q;
					y_after    <= sat32(ypre);
					step_index <= idx_q[IndexW-1:0];
					last       <= (idx_q == (IndexW+1)'(cnt_q - 1'b1));
					divide_fault <= fault_q;
					done       <= 1'b1;
					x_q   <= xf;
					y_q   <= sat32(ypre);
					idx_q <= idx_q + 1'b1;
					if (idx_q == (IndexW+1)'(cnt_q - 1'b1)) zc_q <= 1'b1;
					else done_q <= 1'b1;
					ph_q <= PH_IDLE;
				end
				PH_HDIV: begin
					// h = diff / count, truncated toward zero
					if (dcnt_q < DCntW'(WordW)) begin
						dcnt_q <= dcnt_q + DCntW'(1);
						if (htrial >= {1'b0, cnt_q}) begin
							hrem_q <= CountW'(htrial - {1'b0, cnt_q});
							hquo_q <= {hquo_q[WordW-2:0], 1'b1};
						end else begin
							hrem_q <= htrial[CountW-1:0];
							hquo_q <= {hquo_q[WordW-2:0], 1'b0};
						end
					end else begin
						h_q    <= hsat;
						hh_q   <= hsat >>> 1;
						done_q <= 1'b1;
						ph_q   <= PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	assign status = '{done: done_q, zero_count: zc_q};

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results back to back");
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DIV) |-> (quo_q <= ((WordW+1)'(1) << FRAC_BITS)))
		else $error("slope above one");
	a_fault_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DIV && den_q == '0) |=> fault_q)
		else $error("fault lost");

endmodule
